FILE: hw/rtl/rosi_pkg.sv
// ============================================================================
// rosi_pkg - shared types and codes for the ray / oriented-box slab test
// Holds the request and response payloads, the flow word that travels down
// the row of axis cells, the item mode codes and the register indexes.
// ============================================================================
package rosi_pkg;

    localparam int WORD_W = 32;
    localparam int QUO_W  = 32;

    // item mode codes
    localparam logic [1:0] MODE_LOAD_AXIS = 2'd0;
    localparam logic [1:0] MODE_LOAD_POS  = 2'd1;
    localparam logic [1:0] MODE_TEST      = 2'd2;
    localparam logic [1:0] MODE_UNUSED    = 2'd3;

    // axis index that names no box axis
    localparam logic [1:0] AXIS_NONE = 2'd3;

    // register indexes
    localparam logic CFG_NEAR_CLIP = 1'b0;
    localparam logic CFG_FAR_CLIP  = 1'b1;

    localparam logic signed [WORD_W-1:0] NEAR_CLIP_RESET = 32'sd6554;
    localparam logic signed [WORD_W-1:0] FAR_CLIP_RESET  = 32'sd6553600;

    localparam logic signed [WORD_W-1:0] S32_MAX = 32'h7fff_ffff;
    localparam logic signed [WORD_W-1:0] S32_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [1:0]               mode;
        logic [1:0]               axis_index;
        logic signed [WORD_W-1:0] vec_x;
        logic signed [WORD_W-1:0] vec_y;
        logic signed [WORD_W-1:0] vec_z;
        logic signed [WORD_W-1:0] dir_x;
        logic signed [WORD_W-1:0] dir_y;
        logic signed [WORD_W-1:0] dir_z;
        logic signed [WORD_W-1:0] extent_lo;
        logic signed [WORD_W-1:0] extent_hi;
    } req_t;

    typedef struct packed {
        logic                     hit;
        logic signed [WORD_W-1:0] distance;
    } rsp_t;

    // One slot of the cell row. For a ray: a = center - origin, d = direction,
    // w0/w1 = tmin/tmax. For an axis load: a = axis column, w0/w1 = extents.
    typedef struct packed {
        logic                     is_ray;
        logic [1:0]               axis_sel;
        logic signed [WORD_W-1:0] a_x;
        logic signed [WORD_W-1:0] a_y;
        logic signed [WORD_W-1:0] a_z;
        logic signed [WORD_W-1:0] d_x;
        logic signed [WORD_W-1:0] d_y;
        logic signed [WORD_W-1:0] d_z;
        logic signed [WORD_W-1:0] w0;
        logic signed [WORD_W-1:0] w1;
        logic                     miss;
    } flow_t;

endpackage

FILE: hw/rtl/rosi_div_step.sv
// ============================================================================
// rosi_div_step - one restoring division step
// Decides one quotient bit and trims the remainder; registered, stalls with
// the row.
// ============================================================================
module rosi_div_step #(
    parameter int NW  = 49,
    parameter int BIT = 0
) (
    input  logic                          clk,
    input  logic                          advance,
    input  logic [NW-1:0]                 rem,
    input  logic [rosi_pkg::QUO_W-1:0]    den,
    input  logic [rosi_pkg::QUO_W-1:0]    quo,
    output logic [NW-1:0]                 rem_out,
    output logic [rosi_pkg::QUO_W-1:0]    den_out,
    output logic [rosi_pkg::QUO_W-1:0]    quo_out
);

    localparam logic [rosi_pkg::QUO_W-1:0] QUO_W_ONE = 1;

    logic [63:0] rem_wide;
    logic [63:0] den_shift;
    logic        ge;

    assign rem_wide  = 64'(rem);
    assign den_shift = 64'(den) << BIT;
    assign ge        = rem_wide >= den_shift;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_out <= ge ? NW'(rem_wide - den_shift) : rem;
            den_out <= den;
            quo_out <= quo | (QUO_W_ONE << BIT & {rosi_pkg::QUO_W{ge}});
        end
    end

endmodule

FILE: hw/rtl/rosi_axis_cell.sv
// ============================================================================
// rosi_axis_cell - one box axis of the slab test
// Holds one axis column and its extents, forms e and f, divides for the
// slab distances and narrows the interval; hands the flow word onward.
// ============================================================================
module rosi_axis_cell #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [1:0]        cell_axis,
    input  logic              flow_in_valid,
    input  rosi_pkg::flow_t   flow_in,
    output logic              flow_out_valid,
    output rosi_pkg::flow_t   flow_out
);

    localparam int NW    = 33 + FRAC_BITS;
    localparam int STEPS = rosi_pkg::QUO_W;
    localparam logic [63:0] EPS_WIDE =
        ((64'd1 << FRAC_BITS) * 64'd1000 + 64'd500000) / 64'd1000000;

    typedef struct packed {
        rosi_pkg::flow_t     flow;
        logic signed [31:0]  e;
        logic signed [31:0]  lo;
        logic signed [31:0]  hi;
        logic                par;
        logic                neg1;
        logic                neg2;
        logic                ovf1;
        logic                ovf2;
    } side_t;

    // box state for this axis
    logic signed [31:0] ax_reg [3];
    logic signed [31:0] lo_reg;
    logic signed [31:0] hi_reg;
    logic               cap;

    assign cap = advance && flow_in_valid && !flow_in.is_ray &&
                 (flow_in.axis_sel == cell_axis);

    always_ff @(posedge clk)
    begin
        if (cap)
        begin
            ax_reg[0] <= flow_in.a_x;
            ax_reg[1] <= flow_in.a_y;
            ax_reg[2] <= flow_in.a_z;
            lo_reg    <= flow_in.w0;
            hi_reg    <= flow_in.w1;
        end
    end

    // stage 1: products
    logic                v1_reg;
    rosi_pkg::flow_t     f1_reg;
    logic signed [63:0]  pe_reg [3];
    logic signed [63:0]  pf_reg [3];
    logic signed [31:0]  lo1_reg;
    logic signed [31:0]  hi1_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            f1_reg    <= flow_in;
            pe_reg[0] <= ax_reg[0] * flow_in.a_x;
            pe_reg[1] <= ax_reg[1] * flow_in.a_y;
            pe_reg[2] <= ax_reg[2] * flow_in.a_z;
            pf_reg[0] <= ax_reg[0] * flow_in.d_x;
            pf_reg[1] <= ax_reg[1] * flow_in.d_y;
            pf_reg[2] <= ax_reg[2] * flow_in.d_z;
            lo1_reg   <= lo_reg;
            hi1_reg   <= hi_reg;
        end
    end

    function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
        if ((&v[65:31]) || !(|v[65:31]))
            return v[31:0];
        else
            return v[65] ? rosi_pkg::S32_MIN : rosi_pkg::S32_MAX;
    endfunction

    // stage 2: floor-shifted sums, saturated
    logic                v2_reg;
    rosi_pkg::flow_t     f2_reg;
    logic signed [31:0]  e2_reg;
    logic signed [31:0]  fd2_reg;
    logic signed [31:0]  lo2_reg;
    logic signed [31:0]  hi2_reg;
    logic signed [65:0]  sum_e;
    logic signed [65:0]  sum_f;

    assign sum_e = 66'(pe_reg[0] >>> FRAC_BITS) + 66'(pe_reg[1] >>> FRAC_BITS) +
                   66'(pe_reg[2] >>> FRAC_BITS);
    assign sum_f = 66'(pf_reg[0] >>> FRAC_BITS) + 66'(pf_reg[1] >>> FRAC_BITS) +
                   66'(pf_reg[2] >>> FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            f2_reg  <= f1_reg;
            e2_reg  <= sat66(sum_e);
            fd2_reg <= sat66(sum_f);
            lo2_reg <= lo1_reg;
            hi2_reg <= hi1_reg;
        end
    end

    // stage 3: numerators, divisor, overflow and parallel flags
    logic signed [32:0]  sum1;
    logic signed [32:0]  sum2;
    logic [NW-1:0]       num1;
    logic [NW-1:0]       num2;
    logic [NW-1:0]       mag1;
    logic [NW-1:0]       mag2;
    logic [31:0]         den;
    side_t               side_s3;

    assign sum1 = 33'(e2_reg) + 33'(lo2_reg);
    assign sum2 = 33'(e2_reg) + 33'(hi2_reg);
    assign num1 = {sum1, {FRAC_BITS{1'b0}}};
    assign num2 = {sum2, {FRAC_BITS{1'b0}}};
    assign mag1 = sum1[32] ? NW'(-num1) : num1;
    assign mag2 = sum2[32] ? NW'(-num2) : num2;
    assign den  = fd2_reg[31] ? 32'(-fd2_reg) : fd2_reg;

    always_comb
    begin
        side_s3.flow = f2_reg;
        side_s3.e    = e2_reg;
        side_s3.lo   = lo2_reg;
        side_s3.hi   = hi2_reg;
        side_s3.par  = !(64'(den) > EPS_WIDE);
        side_s3.neg1 = sum1[32] ^ fd2_reg[31];
        side_s3.neg2 = sum2[32] ^ fd2_reg[31];
        side_s3.ovf1 = 64'(mag1) >= {den, 32'd0};
        side_s3.ovf2 = 64'(mag2) >= {den, 32'd0};
    end

    logic                rem1_s3_reg;
    logic [NW-1:0]       m1_reg;
    logic [NW-1:0]       m2_reg;
    logic [31:0]         den_reg;

    // divider rows plus a matching sideband line
    logic [NW-1:0] rem1_w [STEPS+1];
    logic [NW-1:0] rem2_w [STEPS+1];
    logic [31:0]   den1_w [STEPS+1];
    logic [31:0]   den2_w [STEPS+1];
    logic [31:0]   quo1_w [STEPS+1];
    logic [31:0]   quo2_w [STEPS+1];
    side_t         side_reg [STEPS+1];
    logic          vs_reg   [STEPS+1];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m1_reg      <= mag1;
            m2_reg      <= mag2;
            den_reg     <= den;
            side_reg[0] <= side_s3;
            for (int k = 1; k <= STEPS; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    assign rem1_s3_reg = 1'b0;
    assign rem1_w[0] = m1_reg;
    assign rem2_w[0] = m2_reg;
    assign den1_w[0] = den_reg;
    assign den2_w[0] = den_reg | {31'd0, rem1_s3_reg};
    assign quo1_w[0] = '0;
    assign quo2_w[0] = '0;

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        rosi_div_step #(.NW(NW), .BIT(STEPS - 1 - k)) u_div1 (
            .clk     (clk),
            .advance (advance),
            .rem     (rem1_w[k]),
            .den     (den1_w[k]),
            .quo     (quo1_w[k]),
            .rem_out (rem1_w[k+1]),
            .den_out (den1_w[k+1]),
            .quo_out (quo1_w[k+1])
        );
        rosi_div_step #(.NW(NW), .BIT(STEPS - 1 - k)) u_div2 (
            .clk     (clk),
            .advance (advance),
            .rem     (rem2_w[k]),
            .den     (den2_w[k]),
            .quo     (quo2_w[k]),
            .rem_out (rem2_w[k+1]),
            .den_out (den2_w[k+1]),
            .quo_out (quo2_w[k+1])
        );
    end

    // valid line through all stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            for (int k = 0; k <= STEPS; k++)
                vs_reg[k] <= 1'b0;
            flow_out_valid <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg    <= flow_in_valid;
            v2_reg    <= v1_reg;
            vs_reg[0] <= v2_reg;
            for (int k = 1; k <= STEPS; k++)
                vs_reg[k] <= vs_reg[k-1];
            flow_out_valid <= vs_reg[STEPS];
        end
    end

    function automatic logic signed [31:0] sat_quo(input logic neg, input logic ovf,
                                                   input logic [31:0] q);
        if (neg)
        begin
            if (ovf || (q[31] && (|q[30:0])))
                return rosi_pkg::S32_MIN;
            else
                return 32'(-q);
        end
        else
        begin
            if (ovf || q[31])
                return rosi_pkg::S32_MAX;
            else
                return q;
        end
    endfunction

    // final stage: order the slab distances and narrow the interval
    side_t               sd;
    logic signed [31:0]  t1;
    logic signed [31:0]  t2;
    logic signed [31:0]  ta;
    logic signed [31:0]  tb;
    logic signed [31:0]  tmin_n;
    logic signed [31:0]  tmax_n;
    rosi_pkg::flow_t     flow_next;

    assign sd = side_reg[STEPS];
    assign t1 = sat_quo(sd.neg1, sd.ovf1, quo1_w[STEPS]);
    assign t2 = sat_quo(sd.neg2, sd.ovf2, quo2_w[STEPS]);
    assign ta = (t1 > t2) ? t2 : t1;
    assign tb = (t1 > t2) ? t1 : t2;
    assign tmax_n = (tb < sd.flow.w1) ? tb : sd.flow.w1;
    assign tmin_n = (ta > sd.flow.w0) ? ta : sd.flow.w0;

    always_comb
    begin
        flow_next = sd.flow;
        if (sd.flow.is_ray && !sd.flow.miss)
        begin
            if (sd.par)
            begin
                flow_next.miss = (sd.lo > sd.e) || (sd.hi < sd.e);
            end
            else
            begin
                flow_next.w0   = tmin_n;
                flow_next.w1   = tmax_n;
                flow_next.miss = tmax_n < tmin_n;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            flow_out <= flow_next;
    end

endmodule

FILE: hw/rtl/ray_obb_slab_intersect.sv
// ============================================================================
// ray_obb_slab_intersect - ray versus oriented-box slab test, fixed point
// Streams rays against a loaded box through a row of three axis cells.
// ============================================================================
// Pipeline: 1 entry stage plus 36 stages in each of the three axis cells
//   (products, sums, setup, 32 restoring divide steps, interval update).
// Throughput: one request per cycle while no finished response is held
//   waiting; the divide steps are fully pipelined.
// Reset: clears all valid bits and loads near_clip/far_clip reset values;
//   box storage is undefined until loaded.
module ray_obb_slab_intersect #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              req_valid,
    output logic                              req_ready,
    input  rosi_pkg::req_t                    req,
    // response channel
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output rosi_pkg::rsp_t                    rsp,
    // configuration writes
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [rosi_pkg::WORD_W-1:0]       cfg_data
);

    localparam int NCELL = 3;

    logic advance;
    logic acc;

    // Whole row moves together; hold everything while a finished response
    // waits for its transfer.
    assign advance   = !rsp_valid || rsp_ready;
    assign req_ready = advance;
    assign acc       = req_valid && req_ready;

    // clip registers
    logic signed [31:0] near_reg;
    logic signed [31:0] far_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_reg <= rosi_pkg::NEAR_CLIP_RESET;
            far_reg  <= rosi_pkg::FAR_CLIP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rosi_pkg::CFG_NEAR_CLIP: near_reg <= cfg_data;
                rosi_pkg::CFG_FAR_CLIP:  far_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Box position lives at the entry: a ray picks up center - origin on its
    // transfer, so later position loads never disturb rays in flight.
    logic signed [31:0] center_reg [3];
    logic signed [31:0] org [3];
    logic signed [31:0] delta [3];

    assign org[0] = req.vec_x;
    assign org[1] = req.vec_y;
    assign org[2] = req.vec_z;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            logic signed [32:0] diff;
            diff = 33'(center_reg[c]) - 33'(org[c]);
            if (diff[32] == diff[31])
                delta[c] = diff[31:0];
            else
                delta[c] = diff[32] ? rosi_pkg::S32_MIN : rosi_pkg::S32_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && req.mode == rosi_pkg::MODE_LOAD_POS)
        begin
            center_reg[0] <= req.vec_x;
            center_reg[1] <= req.vec_y;
            center_reg[2] <= req.vec_z;
        end
    end

    // entry stage: build the flow word
    logic             ent_valid_reg;
    rosi_pkg::flow_t  ent_flow_reg;
    rosi_pkg::flow_t  ent_flow;
    logic             ent_take;

    // Axis loads and rays enter the row; position loads and the unused mode
    // end here.
    assign ent_take = acc && (req.mode == rosi_pkg::MODE_LOAD_AXIS ||
                              req.mode == rosi_pkg::MODE_TEST);

    always_comb
    begin
        ent_flow.is_ray   = req.mode == rosi_pkg::MODE_TEST;
        ent_flow.axis_sel = req.axis_index;
        ent_flow.d_x      = req.dir_x;
        ent_flow.d_y      = req.dir_y;
        ent_flow.d_z      = req.dir_z;
        ent_flow.miss     = 1'b0;
        if (req.mode == rosi_pkg::MODE_TEST)
        begin
            ent_flow.a_x = delta[0];
            ent_flow.a_y = delta[1];
            ent_flow.a_z = delta[2];
            ent_flow.w0  = near_reg;
            ent_flow.w1  = far_reg;
        end
        else
        begin
            ent_flow.a_x = req.vec_x;
            ent_flow.a_y = req.vec_y;
            ent_flow.a_z = req.vec_z;
            ent_flow.w0  = req.extent_lo;
            ent_flow.w1  = req.extent_hi;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ent_valid_reg <= 1'b0;
        else if (advance)
            ent_valid_reg <= ent_take;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            ent_flow_reg <= ent_flow;
    end

    // Row of axis cells x, y, z. Each keeps its own axis column and extents,
    // captured as the matching axis load passes, so loads and rays stay in
    // transfer order.
    logic            cv [NCELL+1];
    rosi_pkg::flow_t cf [NCELL+1];

    assign cv[0] = ent_valid_reg;
    assign cf[0] = ent_flow_reg;

    for (genvar g = 0; g < NCELL; g++)
    begin : g_cell
        rosi_axis_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .advance        (advance),
            .cell_axis      (2'(g)),
            .flow_in_valid  (cv[g]),
            .flow_in        (cf[g]),
            .flow_out_valid (cv[g+1]),
            .flow_out       (cf[g+1])
        );
    end

    // The last cell's output register is the response register; axis loads
    // drop out here without a response.
    assign rsp_valid    = cv[NCELL] && cf[NCELL].is_ray;
    assign rsp.hit      = !cf[NCELL].miss;
    assign rsp.distance = cf[NCELL].miss ? '0 : cf[NCELL].w0;

endmodule
